[design/lpdh_pkg.sv]
package lpdh_pkg;

	localparam int HEADER_BYTES = 4;
	localparam int LEN_BYTES    = 4;
	localparam int HDR_CNT_W    = $clog2(HEADER_BYTES + 1);
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_PROBE = 8'h48;
	localparam logic [7:0] CH_ACK   = 8'h41;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [2:0] KIND_PAYLOAD = 3'd0;
	localparam logic [2:0] KIND_EMPTY   = 3'd1;
	localparam logic [2:0] KIND_REPLY   = 3'd2;
	localparam logic [2:0] KIND_ACK     = 3'd3;
	localparam logic [2:0] KIND_DROPPED = 3'd4;
	localparam logic [2:0] KIND_PROBE   = 3'd5;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  payload_byte;
		logic        frame_end;
		logic [31:0] frame_length;
	} lpdh_rec_t;

	typedef struct packed {
		logic      valid;
		lpdh_rec_t rec;
	} lpdh_slot_t;

endpackage

[design/lpdh_in_if.sv]
interface lpdh_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] rx_byte;

	modport source (output valid, output command, output rx_byte, input ready);
	modport sink (input valid, input command, input rx_byte, output ready);
endinterface

[design/lpdh_out_if.sv]
interface lpdh_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  payload_byte;
	logic        frame_end;
	logic [31:0] frame_length;

	modport source (output valid, output kind, output payload_byte, output frame_end,
		output frame_length, input ready);
	modport sink (input valid, input kind, input payload_byte, input frame_end,
		input frame_length, output ready);
endinterface

[design/lpdh_front.sv]
module lpdh_front import lpdh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	lpdh_in_if.sink    in,
	input  logic       q_full,
	output lpdh_slot_t push
);

	localparam logic ST_HEADER  = 1'b0;
	localparam logic ST_PAYLOAD = 1'b1;

	logic                 state_q, state_d;
	logic [HDR_CNT_W-1:0] hdr_cnt_q, hdr_cnt_d;
	logic [31:0]          len_q, len_d;
	logic [31:0]          left_q, left_d;
	logic                 alive_q, alive_d;
	logic                 client_q;
	logic                 accept;
	logic [31:0]          len_hdr;
	logic                 last_hdr;
	logic                 last_byte;

	assign in.ready = !q_full;
	assign accept   = in.valid && in.ready;
	assign last_hdr = (hdr_cnt_q == HDR_CNT_W'(HEADER_BYTES - 1));
	assign last_byte = (left_q <= 32'd1);

	always_comb begin
		len_hdr = (hdr_cnt_q == '0) ? 32'd0 : len_q;
		for (int i = 0; i < LEN_BYTES; i++) begin
			if (i < HEADER_BYTES && hdr_cnt_q == HDR_CNT_W'(i)) begin
				len_hdr[8*i +: 8] = in.rx_byte;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		hdr_cnt_d = hdr_cnt_q;
		len_d     = len_q;
		left_d    = left_q;
		alive_d   = alive_q;
		push      = '0;
		if (accept) begin
			if (in.command == CMD_TICK) begin
				alive_d = 1'b0;
				if (!alive_q) begin
					push.valid    = 1'b1;
					push.rec.kind = KIND_DROPPED;
				end else if (client_q) begin
					push.valid    = 1'b1;
					push.rec.kind = KIND_PROBE;
				end
			end else begin
				unique case (state_q)
					ST_HEADER: begin
						len_d = len_hdr;
						if (last_hdr) begin
							hdr_cnt_d = '0;
							if (len_hdr == 32'd0) begin
								push.valid    = 1'b1;
								push.rec.kind = KIND_EMPTY;
							end else begin
								state_d = ST_PAYLOAD;
								left_d  = len_hdr;
							end
						end else begin
							hdr_cnt_d = hdr_cnt_q + 1'b1;
						end
					end
					ST_PAYLOAD: begin
						push.valid = 1'b1;
						if (len_q == 32'd1 && (in.rx_byte == CH_PROBE || in.rx_byte == CH_ACK)) begin
							state_d               = ST_HEADER;
							left_d                = 32'd0;
							alive_d               = 1'b1;
							push.rec.kind         = (in.rx_byte == CH_PROBE) ? KIND_REPLY : KIND_ACK;
							push.rec.frame_length = 32'd1;
						end else begin
							push.rec.kind         = KIND_PAYLOAD;
							push.rec.payload_byte = in.rx_byte;
							push.rec.frame_end    = last_byte;
							push.rec.frame_length = len_q;
							if (last_byte) begin
								state_d = ST_HEADER;
								left_d  = 32'd0;
							end else begin
								left_d = left_q - 32'd1;
							end
						end
					end
					default: state_d = ST_HEADER;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_HEADER;
			hdr_cnt_q <= '0;
			len_q     <= '0;
			left_q    <= '0;
			alive_q   <= 1'b0;
			client_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			hdr_cnt_q <= hdr_cnt_d;
			len_q     <= len_d;
			left_q    <= left_d;
			alive_q   <= alive_d;
			if (cfg_we) begin
				client_q <= cfg_wdata;
			end
		end
	end

endmodule

[design/lpdh_queue.sv]
module lpdh_queue import lpdh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  lpdh_slot_t push,
	output logic       full,
	output lpdh_slot_t head,
	input  logic       pop
);

	lpdh_rec_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.rec   = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/lpdh_back.sv]
module lpdh_back import lpdh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  lpdh_slot_t head,
	output logic       pop,
	lpdh_out_if.source out
);

	logic      valid_q;
	lpdh_rec_t rec_q;

	assign pop = head.valid && (!valid_q || out.ready);

	assign out.valid        = valid_q;
	assign out.kind         = rec_q.kind;
	assign out.payload_byte = rec_q.payload_byte;
	assign out.frame_end    = rec_q.frame_end;
	assign out.frame_length = rec_q.frame_length;

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= head.rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out.ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

[design/length_prefix_deframer_heartbeat.sv]
// A result is written into the queue and then registered in the output stage before it reaches the output.
// Throughput: one input transaction per cycle unless the queue is full; header bytes and quiet ticks give no result.
// The four-entry queue between deframer and output stage absorbs output stalls.
// Input ready drops only while that queue is full.
// Asynchronous active-low reset clears the deframing state, alive flag, role and queue.
module length_prefix_deframer_heartbeat import lpdh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	lpdh_in_if.sink     in,
	lpdh_out_if.source  out
);

	lpdh_slot_t push;
	lpdh_slot_t head;
	logic       q_full;
	logic       pop;

	lpdh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in        (in),
		.q_full    (q_full),
		.push      (push)
	);

	lpdh_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	lpdh_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.out    (out)
	);

endmodule

[design/lpdh_checker.sv]
module lpdh_checker import lpdh_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  out_kind,
	input logic [7:0]  out_payload_byte,
	input logic        out_frame_end,
	input logic [31:0] out_frame_length
);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind)
			&& $stable(out_payload_byte) && $stable(out_frame_end)
			&& $stable(out_frame_length))
		else $error("Stalled output transaction changed.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_frame_end |-> out_kind == KIND_PAYLOAD)
		else $error("Frame end marked on a non-payload result.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == KIND_DROPPED || out_kind == KIND_PROBE)
			|-> out_frame_length == 32'd0 && out_payload_byte == 8'd0)
		else $error("Heartbeat tick result carries frame data.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == KIND_REPLY || out_kind == KIND_ACK)
			|-> out_frame_length == 32'd1 && out_payload_byte == 8'd0)
		else $error("Heartbeat frame result has a wrong length.");

endmodule

bind length_prefix_deframer_heartbeat lpdh_checker u_lpdh_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out.valid),
	.out_ready        (out.ready),
	.out_kind         (out.kind),
	.out_payload_byte (out.payload_byte),
	.out_frame_end    (out.frame_end),
	.out_frame_length (out.frame_length)
);

[sim/length_prefix_deframer_heartbeat_tb.sv]
`timescale 1ns / 100ps

module length_prefix_deframer_heartbeat_tb;
	import lpdh_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int ITEMS_PER_RUN = 450;
	localparam int SETTLE_CYCLES = 6;

	class deframe_scoreboard;
		lpdh_rec_t   expected_q[$];
		bit          client_role;
		bit          in_payload;
		int unsigned header_count;
		logic [31:0] length_accum;
		logic [31:0] bytes_left;
		bit          alive_flag;
		int          errors;

		function new();
			client_role  = 0;
			in_payload   = 0;
			header_count = 0;
			length_accum = '0;
			bytes_left   = '0;
			alive_flag   = 0;
			errors       = 0;
		endfunction

		function void set_role(bit value);
			client_role = value;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void report(string msg);
			if (errors < 40)
				$display("%0t: mismatch: %s", $realtime, msg);
			errors++;
		endfunction

		function void push_result(logic [2:0] kind, logic [7:0] data, logic last,
				logic [31:0] len);
			lpdh_rec_t rec;
			rec.kind         = kind;
			rec.payload_byte = data;
			rec.frame_end    = last;
			rec.frame_length = len;
			expected_q = {expected_q, rec};
		endfunction

		function void note_input(logic command, logic [7:0] rx_byte);
			logic last;
			if (command == CMD_TICK) begin
				if (!alive_flag)
					push_result(KIND_DROPPED, 8'h00, 1'b0, 32'h0);
				else if (client_role)
					push_result(KIND_PROBE, 8'h00, 1'b0, 32'h0);
				alive_flag = 0;
				return;
			end
			if (!in_payload) begin
				if (header_count == 0)
					length_accum = '0;
				if (header_count < LEN_BYTES)
					length_accum |= 32'(rx_byte) << (8 * header_count);
				header_count++;
				if (header_count >= HEADER_BYTES) begin
					header_count = 0;
					if (length_accum == 0) begin
						push_result(KIND_EMPTY, 8'h00, 1'b0, 32'h0);
					end else begin
						in_payload = 1;
						bytes_left = length_accum;
					end
				end
				return;
			end
			if (length_accum == 1 && (rx_byte == CH_PROBE || rx_byte == CH_ACK)) begin
				in_payload = 0;
				bytes_left = '0;
				alive_flag = 1;
				push_result((rx_byte == CH_PROBE) ? KIND_REPLY : KIND_ACK, 8'h00, 1'b0,
					32'h1);
				return;
			end
			last = (bytes_left <= 1);
			bytes_left = last ? 32'h0 : bytes_left - 1;
			if (last)
				in_payload = 0;
			push_result(KIND_PAYLOAD, rx_byte, last, length_accum);
		endfunction

		function void check(lpdh_rec_t got);
			lpdh_rec_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result kind=%0d byte=%02h end=%0d len=%08h",
					got.kind, got.payload_byte, got.frame_end, got.frame_length));
				return;
			end
			want = expected_q.pop_front();
			if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
					got.frame_end !== want.frame_end ||
					got.frame_length !== want.frame_length)
				report($sformatf("got kind=%0d byte=%02h end=%0d len=%08h, want kind=%0d byte=%02h end=%0d len=%08h",
					got.kind, got.payload_byte, got.frame_end, got.frame_length,
					want.kind, want.payload_byte, want.frame_end, want.frame_length));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	lpdh_in_if  in_ch();
	lpdh_out_if out_ch();

	deframe_scoreboard sb;
	int send_idle;
	int recv_idle;
	int items_sent;
	int cycle_count;

	length_prefix_deframer_heartbeat uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in        (in_ch),
		.out       (out_ch)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check('{kind: out_ch.kind, payload_byte: out_ch.payload_byte,
				frame_end: out_ch.frame_end, frame_length: out_ch.frame_length});
		out_ch.ready <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	task automatic send_item(input logic command, input logic [7:0] rx_byte);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.command <= command;
		in_ch.rx_byte <= rx_byte;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_input(command, rx_byte);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] rx_byte);
		if ($urandom_range(99) < 5)
			send_item(CMD_TICK, 8'($urandom_range(255)));
		send_item(CMD_BYTE, rx_byte);
	endtask

	task automatic send_frame(input logic [31:0] len, input bit beat, input logic [7:0] beat_byte);
		logic [7:0] data;
		for (int i = 0; i < HEADER_BYTES; i++)
			send_byte((i < LEN_BYTES) ? len[8 * i +: 8] : 8'($urandom_range(255)));
		if (beat) begin
			send_byte(beat_byte);
			return;
		end
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(9))
				0: data = CH_PROBE;
				1: data = CH_ACK;
				default: data = 8'($urandom_range(255));
			endcase
			send_byte(data);
		end
	endtask

	task automatic send_random_frame();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			send_frame(32'd0, 0, 8'h00);
		else if (pick < 22)
			send_frame(32'd1, 1, CH_PROBE);
		else if (pick < 34)
			send_frame(32'd1, 1, CH_ACK);
		else if (pick < 40)
			send_frame(32'd1, 0, 8'h00);
		else if (pick < 42)
			send_frame(32'($urandom_range(256, 300)), 0, 8'h00);
		else
			send_frame(32'($urandom_range(2, 12)), 0, 8'h00);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_role(input logic value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		sb.set_role(value);
	endtask

	initial begin
		sb = new();
		send_idle   = 0;
		recv_idle   = 0;
		items_sent  = 0;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= 1'b0;
		in_ch.valid   <= 1'b0;
		in_ch.command <= CMD_BYTE;
		in_ch.rx_byte <= 8'h00;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_role(1'b0);
		send_item(CMD_TICK, 8'h00);
		send_frame(32'd0, 0, 8'h00);
		send_frame(32'd1, 1, CH_PROBE);
		send_item(CMD_TICK, 8'hFF);
		send_frame(32'd1, 1, CH_ACK);
		send_frame(32'd1, 1, 8'hFF);
		send_item(CMD_BYTE, 8'h02);
		repeat (3) send_item(CMD_BYTE, 8'h00);
		send_item(CMD_BYTE, CH_PROBE);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_BYTE, 8'h00);
		send_item(CMD_TICK, 8'h00);
		drain();

		write_role(1'b1);
		send_frame(32'd1, 1, CH_ACK);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_TICK, 8'h00);
		drain();

		for (int run = 0; run < 3; run++) begin
			case (run)
				0: begin
					send_idle = 13;
					recv_idle = 65;
				end
				1: begin
					send_idle = 65;
					recv_idle = 13;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			items_sent = 0;
			while (items_sent < ITEMS_PER_RUN)
				send_random_frame();
			drain();
			write_role(run[0]);
		end

		send_idle = 13;
		recv_idle = 40;
		for (int i = 0; i < HEADER_BYTES; i++)
			send_item(CMD_BYTE, 8'hFF);
		for (int i = 0; i < 20; i++)
			send_byte(8'($urandom_range(255)));
		drain();

		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
